// ----- rtl/tmme_pkg.sv -----
// shared opcodes, stream field widths and control struct for the tiny memory machine executor
package tmme_pkg;

  // stream field widths
  localparam int unsigned OP_W   = 4;
  localparam int unsigned OPND_W = 4;
  localparam int unsigned IV_W   = 32;
  localparam int unsigned NI_W   = 16;
  localparam int unsigned OV_W   = 32;

  // packed tdata widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 56;

  typedef enum logic [OP_W-1:0] {
    OP_EXIT     = 4'd0,
    OP_LOAD     = 4'd1,
    OP_SAVE     = 4'd2,
    OP_ADD      = 4'd3,
    OP_SUB      = 4'd4,
    OP_GREATER  = 4'd5,
    OP_LESS     = 4'd6,
    OP_EQUAL    = 4'd7,
    OP_BRANCH   = 4'd8,
    OP_INPUT    = 4'd9,
    OP_OUTPUT   = 4'd10,
    OP_GOTO     = 4'd11,
    OP_PERSIST  = 4'd12,
    OP_RELOAD   = 4'd13,
    OP_CONSTANT = 4'd14,
    OP_MOVE     = 4'd15
  } op_t;

  // decoded effects of one instruction
  typedef struct packed {
    logic ram_we;
    logic store_we;
    logic halt_set;
    logic out_valid;
    logic persist;
    logic reload;
  } ctrl_t;

endpackage

// ----- rtl/tmme_ram.sv -----
// generic single write port ram with registered read
module tmme_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/tmme_alu.sv -----
// instruction execute logic: operand results, memory writes and counter update
module tmme_alu
  import tmme_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned PC_WIDTH   = 16,
  parameter int unsigned ADDR_W     = 4
) (
  input  op_t                    op,
  input  logic [OPND_W-1:0]      opnd_a,
  input  logic [OPND_W-1:0]      opnd_b,
  input  logic [OPND_W-1:0]      opnd_c,
  input  logic signed [IV_W-1:0] in_val,
  input  logic [DATA_WIDTH-1:0]  val1,
  input  logic [DATA_WIDTH-1:0]  val2,
  input  logic [DATA_WIDTH-1:0]  store_val,
  input  logic [PC_WIDTH-1:0]    pc,
  input  logic                   stopped,
  output ctrl_t                  ctrl,
  output logic [ADDR_W-1:0]      ram_waddr,
  output logic [DATA_WIDTH-1:0]  ram_wdata,
  output logic [ADDR_W-1:0]      store_waddr,
  output logic [DATA_WIDTH-1:0]  store_wdata,
  output logic [PC_WIDTH-1:0]    pc_next
);

  logic [63:0]           iv_ext;
  logic [DATA_WIDTH-1:0] sum;
  logic [DATA_WIDTH-1:0] diff;
  logic                  gt;
  logic                  lt;

  assign iv_ext = 64'(in_val);
  assign sum    = val1 + val2;
  assign diff   = val1 - val2;
  assign gt     = $signed(val1) > $signed(val2);
  assign lt     = $signed(val2) > $signed(val1);

  // store write always comes from ram[a] into slot b
  assign store_waddr = ADDR_W'(opnd_b);
  assign store_wdata = val1;

  // opcode decode
  always_comb begin
    ctrl      = '0;
    ram_waddr = ADDR_W'(opnd_a);
    ram_wdata = '0;
    pc_next   = pc + PC_WIDTH'(1);
    if (stopped) begin
      pc_next = pc;
    end else begin
      unique case (op)
        OP_EXIT: begin
          ctrl.halt_set = 1'b1;
          pc_next       = pc;
        end
        OP_LOAD: begin
          ctrl.ram_we = 1'b1;
          ram_waddr   = ADDR_W'(opnd_b);
          ram_wdata   = store_val;
        end
        OP_SAVE: begin
          ctrl.store_we = 1'b1;
        end
        OP_ADD: begin
          ctrl.ram_we = 1'b1;
          ram_wdata   = sum;
        end
        OP_SUB: begin
          ctrl.ram_we = 1'b1;
          ram_wdata   = diff;
        end
        OP_GREATER: begin
          ctrl.ram_we = 1'b1;
          ram_wdata   = DATA_WIDTH'(gt);
        end
        OP_LESS: begin
          ctrl.ram_we = 1'b1;
          ram_wdata   = DATA_WIDTH'(lt);
        end
        OP_EQUAL: begin
          ctrl.ram_we = 1'b1;
          ram_wdata   = DATA_WIDTH'(val1 == val2);
        end
        OP_BRANCH: begin
          pc_next = (val1 != '0) ? PC_WIDTH'(opnd_b) : PC_WIDTH'(opnd_c);
        end
        OP_INPUT: begin
          ctrl.ram_we = 1'b1;
          ram_wdata   = DATA_WIDTH'(iv_ext);
        end
        OP_OUTPUT: begin
          ctrl.out_valid = 1'b1;
        end
        OP_GOTO: begin
          pc_next = PC_WIDTH'(opnd_a);
        end
        OP_PERSIST: begin
          ctrl.persist = 1'b1;
        end
        OP_RELOAD: begin
          ctrl.reload = 1'b1;
        end
        OP_CONSTANT: begin
          ctrl.ram_we = 1'b1;
          ram_waddr   = ADDR_W'(opnd_b);
          ram_wdata   = DATA_WIDTH'(opnd_a);
        end
        OP_MOVE: begin
          ctrl.ram_we = 1'b1;
          ram_waddr   = ADDR_W'(opnd_b);
          ram_wdata   = val1;
        end
        default: begin
          pc_next = pc;
        end
      endcase
    end
  end

endmodule

// ----- rtl/tiny_memory_machine_executor_top.sv -----
// Top level of the tiny memory machine executor: operand fetch, execute and result register.
// Each item passes the ram read register, then the result register, to become a result item.
// Throughput: one item per cycle unless out_tready stalls; one write, two working ram reads each.
// A write from the instruction ahead is forwarded to operands read in the same cycle.
// Reset (rst_n low, synchronous) clears counter, halt flag, pipeline valids and per-entry
// valid bits, so both memories read as zero right after reset with no clearing pass.
module tiny_memory_machine_executor_top
  import tmme_pkg::*;
#(
  parameter int unsigned MEM_DEPTH  = 16,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned PC_WIDTH   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // mode[3:0], operand_first[7:4], operand_second[11:8], operand_third[15:12],
  // input_value[47:16]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // next_instruction[15:0], halted[16], out_valid[17], out_value[49:18],
  // persist_request[50], reload_request[51], zero pad[55:52]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned AW = $clog2(MEM_DEPTH);

  // input fields
  op_t               in_mode;
  logic [OPND_W-1:0] in_a;
  logic [OPND_W-1:0] in_b;
  logic [OPND_W-1:0] in_c;
  logic [IV_W-1:0]   in_iv;
  logic [AW-1:0]     rd1_addr;
  logic [AW-1:0]     rd2_addr;
  logic [AW-1:0]     st_raddr;
  logic              in_fire;

  assign in_mode  = op_t'(in_tdata[3:0]);
  assign in_a     = in_tdata[7:4];
  assign in_b     = in_tdata[11:8];
  assign in_c     = in_tdata[15:12];
  assign in_iv    = in_tdata[47:16];
  assign rd2_addr = AW'(in_c);
  assign st_raddr = AW'(in_a);

  // first read port address select
  always_comb begin
    unique case (in_mode) inside
      OP_BRANCH, OP_OUTPUT, OP_SAVE, OP_MOVE: rd1_addr = AW'(in_a);
      default:                                rd1_addr = AW'(in_b);
    endcase
  end

  // execute stage registers
  logic              s1_vld_r;
  op_t               s1_op_r;
  logic [OPND_W-1:0] s1_a_r;
  logic [OPND_W-1:0] s1_b_r;
  logic [OPND_W-1:0] s1_c_r;
  logic [IV_W-1:0]   s1_iv_r;
  logic [AW-1:0]     s1_ra1_r;
  logic [AW-1:0]     s1_ra2_r;
  logic [AW-1:0]     s1_sra_r;
  logic              rd1_vld_r;
  logic              rd2_vld_r;
  logic              st_vld_r;

  // machine state
  logic [PC_WIDTH-1:0] pc_r;
  logic                stop_r;
  logic [MEM_DEPTH-1:0] ram_vld_r;
  logic [MEM_DEPTH-1:0] st_vld_bits_r;

  // forwarding of the write done in the cycle an item was read
  logic                  byp_ram_vld_r;
  logic [AW-1:0]         byp_ram_addr_r;
  logic [DATA_WIDTH-1:0] byp_ram_data_r;
  logic                  byp_st_vld_r;
  logic [AW-1:0]         byp_st_addr_r;
  logic [DATA_WIDTH-1:0] byp_st_data_r;

  // result register
  logic                out_vld_r;
  logic [NI_W-1:0]     res_ni_r;
  logic                res_halt_r;
  logic                res_ov_r;
  logic [OV_W-1:0]     res_oval_r;
  logic                res_pr_r;
  logic                res_rr_r;

  logic s1_fire;

  assign s1_fire   = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  // execute signals
  logic [DATA_WIDTH-1:0] q1;
  logic [DATA_WIDTH-1:0] q2;
  logic [DATA_WIDTH-1:0] qs;
  logic [DATA_WIDTH-1:0] val1;
  logic [DATA_WIDTH-1:0] val2;
  logic [DATA_WIDTH-1:0] store_val;
  ctrl_t                 ctrl;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]         st_waddr;
  logic [DATA_WIDTH-1:0] st_wdata;
  logic [PC_WIDTH-1:0]   pc_nxt;
  logic                  ram_we;
  logic                  st_we;

  assign ram_we = s1_fire && ctrl.ram_we;
  assign st_we  = s1_fire && ctrl.store_we;

  // working ram, one copy per read port
  tmme_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MEM_DEPTH)) u_ram1 (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(in_fire), .raddr(rd1_addr), .rdata(q1)
  );

  tmme_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MEM_DEPTH)) u_ram2 (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(in_fire), .raddr(rd2_addr), .rdata(q2)
  );

  // storage memory
  tmme_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MEM_DEPTH)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .re(in_fire), .raddr(st_raddr), .rdata(qs)
  );

  // operand select: forwarded write, then stored entry, else reset value
  always_comb begin
    if (byp_ram_vld_r && byp_ram_addr_r == s1_ra1_r) begin
      val1 = byp_ram_data_r;
    end else begin
      val1 = rd1_vld_r ? q1 : '0;
    end
    if (byp_ram_vld_r && byp_ram_addr_r == s1_ra2_r) begin
      val2 = byp_ram_data_r;
    end else begin
      val2 = rd2_vld_r ? q2 : '0;
    end
    if (byp_st_vld_r && byp_st_addr_r == s1_sra_r) begin
      store_val = byp_st_data_r;
    end else begin
      store_val = st_vld_r ? qs : '0;
    end
  end

  tmme_alu #(.DATA_WIDTH(DATA_WIDTH), .PC_WIDTH(PC_WIDTH), .ADDR_W(AW)) u_alu (
    .op(s1_op_r), .opnd_a(s1_a_r), .opnd_b(s1_b_r), .opnd_c(s1_c_r),
    .in_val(s1_iv_r), .val1(val1), .val2(val2), .store_val(store_val),
    .pc(pc_r), .stopped(stop_r), .ctrl(ctrl), .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata), .store_waddr(st_waddr), .store_wdata(st_wdata),
    .pc_next(pc_nxt)
  );

  // pipeline control and machine state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      pc_r          <= '0;
      stop_r        <= 1'b0;
      ram_vld_r     <= '0;
      st_vld_bits_r <= '0;
      byp_ram_vld_r <= 1'b0;
      byp_st_vld_r  <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_vld_r <= in_tvalid;
      end
      if (s1_fire) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (s1_fire) begin
        pc_r   <= pc_nxt;
        stop_r <= stop_r || ctrl.halt_set;
      end
      if (ram_we) begin
        ram_vld_r[ram_waddr] <= 1'b1;
      end
      if (st_we) begin
        st_vld_bits_r[st_waddr] <= 1'b1;
      end
      if (in_fire) begin
        byp_ram_vld_r <= ram_we;
        byp_st_vld_r  <= st_we;
      end
    end
  end

  // execute stage payload, forwarded data and read-time valid bits
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r        <= in_mode;
      s1_a_r         <= in_a;
      s1_b_r         <= in_b;
      s1_c_r         <= in_c;
      s1_iv_r        <= in_iv;
      s1_ra1_r       <= rd1_addr;
      s1_ra2_r       <= rd2_addr;
      s1_sra_r       <= st_raddr;
      rd1_vld_r      <= ram_vld_r[rd1_addr];
      rd2_vld_r      <= ram_vld_r[rd2_addr];
      st_vld_r       <= st_vld_bits_r[st_raddr];
      byp_ram_addr_r <= ram_waddr;
      byp_ram_data_r <= ram_wdata;
      byp_st_addr_r  <= st_waddr;
      byp_st_data_r  <= st_wdata;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_ni_r   <= NI_W'(32'(pc_nxt));
      res_halt_r <= stop_r || ctrl.halt_set;
      res_ov_r   <= ctrl.out_valid;
      res_oval_r <= ctrl.out_valid ? OV_W'(64'(val1)) : '0;
      res_pr_r   <= ctrl.persist;
      res_rr_r   <= ctrl.reload;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0, res_rr_r, res_pr_r, res_oval_r, res_ov_r, res_halt_r, res_ni_r};

`ifndef ASSERT_OFF
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |=> stop_r)
    else $error("halt flag cleared after exit");

  a_halted_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && stop_r |-> !ram_we && !st_we && pc_nxt == pc_r)
    else $error("halted machine changed state");

  a_halted_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_halt_r |-> !res_ov_r && !res_pr_r && !res_rr_r)
    else $error("flags raised on halted result");

  a_bypass_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (ram_we || st_we) |=> s1_vld_r && (byp_ram_vld_r || byp_st_vld_r))
    else $error("write in read cycle not forwarded");
`endif

endmodule
